// ===== rtl/core/frl_pkg.sv =====
package frl_pkg;

  localparam int unsigned MaxItems  = 1024;
  localparam int unsigned MaxCount  = 1023;
  localparam int unsigned PosW      = $clog2(MaxItems);
  localparam int unsigned LenW      = $clog2(MaxItems + 1);
  localparam int unsigned CntW      = $clog2(MaxCount + 1);
  localparam int unsigned GrpDepth  = MaxCount + 1;

  typedef enum logic [1:0] {
    OpIncrease = 2'd0,
    OpCreate   = 2'd1,
    OpRead     = 2'd2,
    OpUnused   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] item_id;
    logic [9:0] rank;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  ranked_item;
    logic [9:0]  ranked_count;
    logic        saturated;
    logic [10:0] entries_used;
  } out_item_t;

  // datapath step commands
  typedef enum logic [3:0] {
    CmdIdle     = 4'd0,
    CmdClear    = 4'd1,
    CmdLatch    = 4'd2,
    CmdRdPos    = 4'd3,
    CmdLook     = 4'd4,
    CmdAppend   = 4'd5,
    CmdRdCnt    = 4'd6,
    CmdRdHead   = 4'd7,
    CmdSwapA    = 4'd8,
    CmdSwapB    = 4'd9,
    CmdFinish   = 4'd10
  } cmd_e;

  typedef struct packed {
    logic is_inc;
    logic is_create;
    logic present;
    logic full;
    logic sat;
    logic clr_done;
  } dp_status_t;

endpackage

// ===== rtl/core/frl_ram.sv =====
module frl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/frl_datapath.sv =====
module frl_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  frl_pkg::cmd_e       cmd_i,
  input  frl_pkg::in_item_t   in_item_i,
  output frl_pkg::dp_status_t status_o,
  output frl_pkg::out_item_t  result_o
);
  import frl_pkg::*;

  // position and group-head words carry a valid bit on top of the position
  in_item_t        it_q;
  logic [LenW-1:0] len_q;
  logic [PosW-1:0] clr_q;
  logic [PosW-1:0] p_q, h_q, ib_q;
  logic [CntW-1:0] c_q;
  logic            head0_valid_q, head1_valid_q;
  logic            ok_q, sat_q, read_ok_q;
  logic [9:0]      r_item_q;
  logic [CntW-1:0] r_cnt_q;

  // memories
  logic            pos_we, itm_we, cnt_we, grp_we;
  logic [PosW-1:0] pos_wa, pos_ra, itm_wa, itm_ra, cnt_wa, cnt_ra;
  logic [CntW-1:0] grp_wa, grp_ra;
  logic [PosW:0]   pos_wd, pos_rd, grp_wd, grp_rd;
  logic [9:0]      itm_wd, itm_rd;
  logic [CntW-1:0] cnt_wd, cnt_rd;

  logic [LenW-1:0] h_next;
  logic [CntW-1:0] c_inc;
  logic            next_same;
  logic [PosW-1:0] h_sel;

  frl_ram #(.Width(PosW + 1), .Depth(MaxItems)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(pos_wd),
    .raddr_i(pos_ra), .rdata_o(pos_rd));
  frl_ram #(.Width(10), .Depth(MaxItems)) u_itm (
    .clk_i, .we_i(itm_we), .waddr_i(itm_wa), .wdata_i(itm_wd),
    .raddr_i(itm_ra), .rdata_o(itm_rd));
  frl_ram #(.Width(CntW), .Depth(MaxItems)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_wa), .wdata_i(cnt_wd),
    .raddr_i(cnt_ra), .rdata_o(cnt_rd));
  frl_ram #(.Width(PosW + 1), .Depth(GrpDepth)) u_grp (
    .clk_i, .we_i(grp_we), .waddr_i(grp_wa), .wdata_i(grp_wd),
    .raddr_i(grp_ra), .rdata_o(grp_rd));

  assign c_inc     = c_q + 1'b1;
  assign h_next    = {1'b0, h_q} + 1'b1;
  // entry after the head still has the old count: it becomes the new head
  assign next_same = (h_next < len_q) && (cnt_rd == c_q);
  // group head, or p when absent or out of list
  assign h_sel = (grp_rd[PosW] && ({1'b0, grp_rd[PosW-1:0]} < len_q)) ?
                 grp_rd[PosW-1:0] : p_q;

  always_comb begin
    pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_ra = it_q.item_id;
    itm_we = 1'b0; itm_wa = '0; itm_wd = '0; itm_ra = it_q.rank;
    cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = it_q.rank;
    grp_we = 1'b0; grp_wa = '0; grp_wd = '0; grp_ra = '0;
    unique case (cmd_i)
      CmdClear: begin
        pos_we = 1'b1; pos_wa = clr_q;
        grp_we = 1'b1; grp_wa = clr_q;
      end
      CmdLook: cnt_ra = pos_rd[PosW-1:0];
      CmdAppend: begin
        pos_we = 1'b1; pos_wa = it_q.item_id; pos_wd = {1'b1, len_q[PosW-1:0]};
        itm_we = 1'b1; itm_wa = len_q[PosW-1:0]; itm_wd = it_q.item_id;
        cnt_we = 1'b1; cnt_wa = len_q[PosW-1:0];
        grp_we = !head0_valid_q; grp_wd = {1'b1, len_q[PosW-1:0]};
      end
      CmdRdCnt: grp_ra = cnt_rd;
      CmdRdHead: begin
        itm_ra = h_sel;
        // wraps past the last entry; next_same checks h + 1 against the length
        cnt_ra = h_sel + 1'b1;
        grp_ra = c_inc;
      end
      CmdSwapA: begin
        // item moves to h with the raised count, count group c advances
        itm_we = 1'b1; itm_wa = h_q; itm_wd = it_q.item_id;
        pos_we = 1'b1; pos_wa = it_q.item_id; pos_wd = {1'b1, h_q};
        cnt_we = 1'b1; cnt_wa = h_q; cnt_wd = c_inc;
        grp_we = 1'b1; grp_wa = c_q;
        grp_wd = next_same ? {1'b1, h_next[PosW-1:0]} : '0;
      end
      CmdSwapB: begin
        // former head item moves to p
        itm_we = 1'b1; itm_wa = p_q; itm_wd = ib_q;
        pos_we = 1'b1; pos_wa = ib_q; pos_wd = {1'b1, p_q};
        grp_we = !head1_valid_q; grp_wa = c_inc; grp_wd = {1'b1, h_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i == CmdClear) clr_q <= clr_q + 1'b1;
      if (cmd_i == CmdAppend) len_q <= len_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CmdLatch: begin
        it_q  <= in_item_i;
        ok_q  <= 1'b0;
        sat_q <= 1'b0;
      end
      CmdLook: begin
        p_q           <= pos_rd[PosW-1:0];
        ok_q          <= pos_rd[PosW];
        head0_valid_q <= grp_rd[PosW];
        read_ok_q     <= {1'b0, it_q.rank} < len_q;
        r_item_q      <= itm_rd;
        r_cnt_q       <= cnt_rd;
      end
      CmdAppend: ok_q <= 1'b1;
      CmdRdCnt: begin
        c_q   <= cnt_rd;
        sat_q <= status_o.sat;
        if (status_o.sat) ok_q <= 1'b0;
      end
      CmdRdHead: h_q <= h_sel;
      CmdSwapA: begin
        ib_q          <= itm_rd;
        head1_valid_q <= grp_rd[PosW];
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o           = '0;
    status_o.is_inc    = it_q.opcode == OpIncrease;
    status_o.is_create = it_q.opcode == OpCreate;
    status_o.present   = pos_rd[PosW];
    status_o.full      = len_q >= LenW'(MaxItems);
    status_o.sat       = cnt_rd >= CntW'(MaxCount);
    status_o.clr_done  = clr_q == '1;
  end

  always_comb begin
    result_o = '0;
    result_o.entries_used = len_q;
    unique case (it_q.opcode)
      OpRead: if (read_ok_q) begin
        result_o.found        = 1'b1;
        result_o.ranked_item  = r_item_q;
        result_o.ranked_count = r_cnt_q;
      end
      OpCreate: result_o.found = ok_q;
      OpIncrease: begin
        result_o.found     = ok_q;
        result_o.saturated = sat_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/frl_ctrl.sv =====
module frl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  frl_pkg::dp_status_t status_i,
  output frl_pkg::cmd_e       cmd_o
);
  import frl_pkg::*;

  typedef enum logic [9:0] {
    StClr   = 10'b0000000001,
    StIdle  = 10'b0000000010,
    StPos   = 10'b0000000100,
    StLook  = 10'b0000001000,
    StApp   = 10'b0000010000,
    StCnt   = 10'b0000100000,
    StHead  = 10'b0001000000,
    StSwapA = 10'b0010000000,
    StSwapB = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = CmdIdle;
    unique case (state_q)
      StClr: begin
        cmd_o = CmdClear;
        if (status_i.clr_done) state_d = StIdle;
      end
      StIdle: if (in_valid_i && in_ready_o) begin
        cmd_o = CmdLatch; state_d = StPos;
      end
      StPos: begin cmd_o = CmdRdPos; state_d = StLook; end
      StLook: begin
        cmd_o = CmdLook;
        if (status_i.is_inc || status_i.is_create) begin
          if (!status_i.present) state_d = status_i.full ? StOut : StApp;
          else state_d = status_i.is_inc ? StCnt : StOut;
        end else begin
          state_d = StOut;
        end
      end
      StApp: begin
        cmd_o = CmdAppend;
        // an unseen item on increase restarts the lookup after the append
        state_d = status_i.is_inc ? StPos : StOut;
      end
      StCnt: begin
        cmd_o = CmdRdCnt;
        state_d = status_i.sat ? StOut : StHead;
      end
      StHead:  begin cmd_o = CmdRdHead; state_d = StSwapA; end
      StSwapA: begin cmd_o = CmdSwapA;  state_d = StSwapB; end
      StSwapB: begin cmd_o = CmdSwapB;  state_d = StOut; end
      StOut: begin
        cmd_o = CmdFinish; out_valid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |=> out_valid_q) else $error("result not raised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_ready_o == 1'b0) else $error("accept while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q) else $error("result beat dropped");
endmodule

// ===== rtl/core/frequency_ranked_item_list_unit.sv =====
// Frequency-ranked item list. Keeps item ids sorted by descending count in
// on-chip RAMs and serves one operation at a time. After reset the block
// clears its position and group-head memories and takes no item until the
// clear is done. Each operation runs as a chain of dependent registered
// reads and writes of the position, item, count and group-head memories:
// every operation looks up the item's position; a create or increase of an
// unseen item appends it when the list is not full, and an increase then
// repeats the lookup; an increase of a present, unsaturated item reads its
// count, reads the group head and swaps in two steps. The next item is taken
// in the cycle after the result beat has left.
module frequency_ranked_item_list_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  frl_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output frl_pkg::out_item_t out_item_o
);
  import frl_pkg::*;

  cmd_e       cmd;
  dp_status_t status;
  out_item_t  result;
  out_item_t  out_q;

  frl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd));

  frl_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_item_i, .status_o(status),
    .result_o(result));

  always_ff @(posedge clk_i) begin
    if (cmd == CmdFinish) out_q <= result;
  end
  assign out_item_o = out_q;
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import frl_pkg::*;

  localparam int unsigned NumRandom  = 900;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned NoIdx      = 2047;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  frequency_ranked_item_list_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: absent entries hold NoIdx
  int unsigned pos_of_id [MaxItems];
  int unsigned id_at_pos [MaxItems];
  int unsigned cnt_at_pos[MaxItems];
  int unsigned head_of_cnt[GrpDepth];
  int unsigned list_len;

  out_item_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  function automatic out_item_t rank_list_step(in_item_t it);
    out_item_t r;
    int unsigned p, c, h, tmp;
    bit ok;
    r = '0;
    if (it.opcode == OpIncrease || it.opcode == OpCreate) begin
      ok = 1'b1;
      if (pos_of_id[it.item_id] == NoIdx) begin
        if (list_len >= MaxItems) ok = 1'b0;
        else begin
          id_at_pos[list_len] = it.item_id;
          cnt_at_pos[list_len] = 0;
          pos_of_id[it.item_id] = list_len;
          if (head_of_cnt[0] == NoIdx) head_of_cnt[0] = list_len;
          list_len++;
        end
      end
      if (ok && it.opcode == OpIncrease) begin
        p = pos_of_id[it.item_id];
        c = cnt_at_pos[p];
        if (c >= MaxCount) begin
          r.saturated = 1'b1;
          ok = 1'b0;
        end else begin
          h = (head_of_cnt[c] != NoIdx) ? head_of_cnt[c] : p;
          if (h >= list_len) h = p;
          tmp = id_at_pos[h];
          id_at_pos[h] = id_at_pos[p];
          id_at_pos[p] = tmp;
          pos_of_id[id_at_pos[h]] = h;
          pos_of_id[id_at_pos[p]] = p;
          cnt_at_pos[h] = c + 1;
          if (h + 1 < list_len && cnt_at_pos[h + 1] == c) head_of_cnt[c] = h + 1;
          else head_of_cnt[c] = NoIdx;
          if (head_of_cnt[c + 1] == NoIdx) head_of_cnt[c + 1] = h;
        end
      end
      r.found = ok;
    end else if (it.opcode == OpRead && it.rank < list_len) begin
      r.found = 1'b1;
      r.ranked_item = id_at_pos[it.rank][9:0];
      r.ranked_count = cnt_at_pos[it.rank][9:0];
    end
    r.entries_used = list_len[10:0];
    return r;
  endfunction

  // directed table; has_exp marks rows whose result is typed in
  typedef struct {
    op_e         op;
    int unsigned id;
    int unsigned rk;
    bit          has_exp;
    out_item_t   exp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic out_item_t mk(bit f, int unsigned it, int unsigned ct, bit s,
                                   int unsigned n);
    out_item_t r;
    r.found = f;
    r.ranked_item = it[9:0];
    r.ranked_count = ct[9:0];
    r.saturated = s;
    r.entries_used = n[10:0];
    return r;
  endfunction

  task automatic add_row(op_e op, int unsigned id, int unsigned rk, bit he, out_item_t e);
    dir_row_t d;
    d.op = op; d.id = id; d.rk = rk; d.has_exp = he; d.exp = e;
    dir_rows.insert(dir_rows.size(), d);
  endtask

  // sender: drive one beat, hold until accepted
  task automatic send_beat(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic maybe_gap();
    int unsigned g;
    if ($urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      g = $urandom_range(1, 8);
      repeat (g) @(posedge clk_i);
    end
  endtask

  bit typed_queue[$];

  // predict on acceptance so that order matches the block
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      pending_results.insert(pending_results.size(), rank_list_step(in_item_i));
  end

  out_item_t typed_exp[$];

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_item_o);
      end else begin
        e = pending_results.pop_front();
        if (typed_queue.size() != 0 && typed_queue.pop_front()) begin
          if (typed_exp.pop_front() != e) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row disagrees with predictor");
          end
        end
        if (out_item_o !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp found=%0d item=%0d cnt=%0d sat=%0d used=%0d, ",
                      "got %0d %0d %0d %0d %0d"},
                     e.found, e.ranked_item, e.ranked_count, e.saturated, e.entries_used,
                     out_item_o.found, out_item_o.ranked_item, out_item_o.ranked_count,
                     out_item_o.saturated, out_item_o.entries_used);
        end
      end
    end
  end

  // receiver stall pattern: random ready, mostly high with short random stalls
  always @(posedge clk_i) begin
    int unsigned ph;
    ph = $urandom_range(0, 15);
    out_ready_i <= (ph < 11) || (ph == 15 && $urandom_range(0, 1) == 1);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int unsigned n, burst, hot_lo;
    for (int i = 0; i < MaxItems; i++) pos_of_id[i] = NoIdx;
    for (int i = 0; i < GrpDepth; i++) head_of_cnt[i] = NoIdx;
    list_len = 0;

    add_row(OpRead,     0,    0,    1, mk(0, 0, 0, 0, 0));
    add_row(OpRead,     0,    1023, 1, mk(0, 0, 0, 0, 0));
    add_row(OpUnused,   1023, 1023, 1, mk(0, 0, 0, 0, 0));
    add_row(OpCreate,   0,    0,    1, mk(1, 0, 0, 0, 1));
    add_row(OpCreate,   0,    0,    1, mk(1, 0, 0, 0, 1));
    add_row(OpRead,     0,    0,    1, mk(1, 0, 0, 0, 1));
    add_row(OpIncrease, 1023, 0,    1, mk(1, 0, 0, 0, 2));
    add_row(OpRead,     0,    0,    1, mk(1, 1023, 1, 0, 2));
    add_row(OpRead,     0,    1,    1, mk(1, 0, 0, 0, 2));
    add_row(OpRead,     0,    2,    1, mk(0, 0, 0, 0, 2));
    add_row(OpIncrease, 0,    0,    0, '0);
    add_row(OpIncrease, 0,    0,    0, '0);
    add_row(OpCreate,   512,  0,    0, '0);
    add_row(OpIncrease, 512,  0,    0, '0);
    add_row(OpRead,     0,    0,    0, '0);
    add_row(OpRead,     0,    1,    0, '0);
    add_row(OpRead,     0,    2,    0, '0);
    add_row(OpUnused,   0,    0,    1, mk(0, 0, 0, 0, 3));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      it.opcode = dir_rows[i].op;
      it.item_id = dir_rows[i].id[9:0];
      it.rank = dir_rows[i].rk[9:0];
      typed_queue.insert(typed_queue.size(), dir_rows[i].has_exp);
      if (dir_rows[i].has_exp) typed_exp.insert(typed_exp.size(), dir_rows[i].exp);
      send_beat(it);
      maybe_gap();
    end

    // saturate item 1023: drive its count to the maximum, then two more
    for (int k = 0; k < MaxCount + 1; k++) begin
      it.opcode = OpIncrease; it.item_id = 10'd1023; it.rank = '0;
      send_beat(it);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    // hold off until every result is back
    while (pending_results.size() != 0) @(posedge clk_i);

    // random: half increases, mostly on a hot set, with creates, reads and unused opcodes
    n = 0;
    while (n < NumRandom) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < NumRandom; b++) begin
        hot_lo = $urandom_range(0, 3);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
            it.opcode = OpIncrease;
            it.item_id = (hot_lo == 0) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 40));
          end
          10, 11, 12: begin
            it.opcode = OpCreate;
            it.item_id = 10'($urandom_range(0, 1023));
          end
          13: it.opcode = OpUnused;
          default: it.opcode = OpRead;
        endcase
        if (it.opcode != OpIncrease && it.opcode != OpCreate)
          it.item_id = 10'($urandom);
        it.rank = (hot_lo == 0) ? 10'($urandom) : 10'($urandom_range(0, list_len + 2));
        send_beat(it);
        n++;
      end
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end

    // read past the end of the list
    it.opcode = OpRead; it.rank = 10'd1023;
    send_beat(it);
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
